[hdl/predictor_local_sum_core_assert.svh]
// assertion macros shared by the local sum core modules
`ifndef PREDICTOR_LOCAL_SUM_CORE_ASSERT_SVH
`define PREDICTOR_LOCAL_SUM_CORE_ASSERT_SVH

// same-cycle implication
`define LSUM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LSUM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/lsum_pkg.sv]
`default_nettype none
package lsum_pkg;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int MAX_LINE_DEF    = 1024;
	localparam int SUM_W           = 18;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 16;
	localparam int WIDTH_W         = 11;
	localparam int ROWS_W          = 16;
	localparam int MID_W           = 16;
	localparam int MODE_W          = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_SUM_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MID_SAMPLE = 2'd3;

	localparam logic [MODE_W-1:0] MODE_WIDE_NBR   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_NARROW_NBR = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WIDE_COL   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NARROW_COL = 2'd3;

	localparam logic [MODE_W-1:0]  RST_SUM_MODE   = MODE_WIDE_NBR;
	localparam logic [WIDTH_W-1:0] RST_LINE_WIDTH = 11'd1024;
	localparam logic [ROWS_W-1:0]  RST_FRAME_ROWS = 16'd1024;
	localparam logic [MID_W-1:0]   RST_MID_SAMPLE = 16'd32768;

	typedef struct packed {
		logic first_col;
		logic first_row;
		logic band_nz;
		logic right;
		logic origin;
	} pos_t;
endpackage
`default_nettype wire

[hdl/lsum_if.sv]
`default_nettype none
interface lsum_in_if #(
	parameter int SAMPLE_BITS = lsum_pkg::SAMPLE_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample_value;
	logic                   start_of_image;

	modport source (output valid, output sample_value, output start_of_image, input ready);
	modport sink (input valid, input sample_value, input start_of_image, output ready);
endinterface

interface lsum_out_if;
	logic                       valid;
	logic                       ready;
	logic [lsum_pkg::SUM_W-1:0] local_sum;
	logic                       at_band_origin;

	modport source (output valid, output local_sum, output at_band_origin, input ready);
	modport sink (input valid, input local_sum, input at_band_origin, output ready);
endinterface
`default_nettype wire

[hdl/predictor_local_sum_core.sv]
// predictor local sum core
// sample_in takes one image sample per transfer in band-sequential order
// (column fastest, then row, then band); start_of_image restarts the position
// at the first sample of band zero. sum_out gives one local sum per sample,
// in the same order, with at_band_origin set (and the sum zero) at the first
// sample of each band.
// a new sample can be taken every cycle while sum_out is not stalled; a result
// passes through stage 1 and the output register to sum_out. the previous-row line
// store and the store of the previous band's first row are single-port-write,
// one-read memories with registered read data; each sample costs one read in each,
// one line store write, and its above-right read is the above read for the next.
// sum_out has an output register: while it is stalled one more sample is
// still taken into the first stage, then sample_in.ready drops until the
// output is taken. nothing is lost or repeated.
// reset clears the position, the neighbor registers, the pipeline and the
// registers (wide neighbor mode, width 1024, 1024 rows, mid value 32768);
// the stores are not cleared and are written before they are read.
// configuration writes (cfg_write, cfg_index, cfg_data) take effect at once
// and must be made only while no sample is in flight; the block does not enforce it.
`default_nettype none
`include "predictor_local_sum_core_assert.svh"
module predictor_local_sum_core #(
	parameter int SAMPLE_BITS = lsum_pkg::SAMPLE_BITS_DEF,
	parameter int MAX_LINE    = lsum_pkg::MAX_LINE_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	lsum_in_if.sink                                sample_in,
	lsum_out_if.source                             sum_out,
	input  wire logic                              cfg_write,
	input  wire logic [lsum_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [lsum_pkg::CFG_DATA_W-1:0]   cfg_data
);
	localparam int COL_W = $clog2(MAX_LINE);
	localparam int ACC_W = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 2;

	logic [lsum_pkg::MODE_W-1:0]  mode_q;
	logic [lsum_pkg::WIDTH_W-1:0] width_q;
	logic [lsum_pkg::ROWS_W-1:0]  rows_q;
	logic [lsum_pkg::MID_W-1:0]   mid_q;

	logic           take;
	logic           s1_adv;
	logic [COL_W-1:0] x;
	lsum_pkg::pos_t pos;

	logic                   s1_valid_q;
	lsum_pkg::pos_t         pos_s1;
	logic [SAMPLE_BITS-1:0] l_s1;
	logic                   s2_valid_q;
	logic [lsum_pkg::SUM_W-1:0] sum_s2;
	logic                   origin_s2;

	logic [SAMPLE_BITS-1:0] left_q;
	logic [SAMPLE_BITS-1:0] u_q;
	logic [SAMPLE_BITS-1:0] ul_q;

	logic                   fr_pend_q;
	logic [COL_W-1:0]       fr_pend_addr_q;
	logic [SAMPLE_BITS-1:0] fr_pend_data_q;

	logic [COL_W-1:0]       prs_raddr;
	logic [SAMPLE_BITS-1:0] prs_rdata;
	logic                   fr_we_take;
	logic                   fr_we;
	logic [COL_W-1:0]       fr_waddr;
	logic [SAMPLE_BITS-1:0] fr_wdata;
	logic [SAMPLE_BITS-1:0] fr_rdata;

	logic [ACC_W-1:0] a_l;
	logic [ACC_W-1:0] a_u;
	logic [ACC_W-1:0] a_ul;
	logic [ACC_W-1:0] a_ur;
	logic [ACC_W-1:0] a_p;
	logic [ACC_W-1:0] a_mid4;
	logic [ACC_W-1:0] a_first;
	logic [ACC_W-1:0] sum;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= lsum_pkg::RST_SUM_MODE;
			width_q <= lsum_pkg::RST_LINE_WIDTH;
			rows_q  <= lsum_pkg::RST_FRAME_ROWS;
			mid_q   <= lsum_pkg::RST_MID_SAMPLE;
		end else if (cfg_write) begin
			unique case (cfg_index)
				lsum_pkg::CFG_SUM_MODE:   mode_q  <= cfg_data[lsum_pkg::MODE_W-1:0];
				lsum_pkg::CFG_LINE_WIDTH: width_q <= cfg_data[lsum_pkg::WIDTH_W-1:0];
				lsum_pkg::CFG_FRAME_ROWS: rows_q  <= cfg_data[lsum_pkg::ROWS_W-1:0];
				lsum_pkg::CFG_MID_SAMPLE: mid_q   <= cfg_data[lsum_pkg::MID_W-1:0];
				default: ;
			endcase
		end
	end

	assign s1_adv          = s1_valid_q & (~s2_valid_q | sum_out.ready);
	assign sample_in.ready = ~s1_valid_q | s1_adv;
	assign take            = sample_in.valid & sample_in.ready;

	lsum_pos #(
		.MAX_LINE(MAX_LINE)
	) u_pos (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.start      (sample_in.start_of_image),
		.line_width (width_q),
		.frame_rows (rows_q),
		.x          (x),
		.pos        (pos)
	);

	// previous-row store: above-right read now, above value for the next sample
	assign prs_raddr = pos.right ? '0 : x + COL_W'(1);

	lsum_ram #(
		.DEPTH (MAX_LINE),
		.WIDTH (SAMPLE_BITS)
	) u_prior_row (
		.clk   (clk),
		.we    (take),
		.waddr (x),
		.wdata (sample_in.sample_value),
		.re    (take),
		.raddr (prs_raddr),
		.rdata (prs_rdata)
	);

	// first-row store: the right-edge entry is held in a pending register and written in the following cycle
	assign fr_we_take = take & pos.first_row & ~pos.first_col;
	assign fr_we      = fr_pend_q | fr_we_take;
	assign fr_waddr   = fr_pend_q ? fr_pend_addr_q : x - COL_W'(1);
	assign fr_wdata   = fr_pend_q ? fr_pend_data_q : left_q;

	lsum_ram #(
		.DEPTH (MAX_LINE),
		.WIDTH (SAMPLE_BITS)
	) u_first_row (
		.clk   (clk),
		.we    (fr_we),
		.waddr (fr_waddr),
		.wdata (fr_wdata),
		.re    (take),
		.raddr (x - COL_W'(1)),
		.rdata (fr_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_pend_q <= 1'b0;
		end else begin
			fr_pend_q <= take & pos.first_row & pos.right;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			fr_pend_addr_q <= x;
			fr_pend_data_q <= sample_in.sample_value;
		end
	end

	// neighbor registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			u_q    <= '0;
			ul_q   <= '0;
		end else begin
			if (take) begin
				left_q <= sample_in.sample_value;
			end
			if (s1_adv) begin
				u_q  <= prs_rdata;
				ul_q <= u_q;
			end
		end
	end

	// stage 1: store reads in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= take | (s1_valid_q & ~s1_adv);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pos_s1 <= pos;
			l_s1   <= left_q;
		end
	end

	always_comb begin
		a_l    = ACC_W'(l_s1);
		a_u    = ACC_W'(u_q);
		a_ul   = ACC_W'(ul_q);
		a_ur   = pos_s1.right ? '0 : ACC_W'(prs_rdata);
		a_p    = ACC_W'(fr_rdata);
		a_mid4 = ACC_W'(mid_q) << 2;
		a_first = pos_s1.band_nz ? (a_p << 2) : a_mid4;
		sum    = '0;
		if (!pos_s1.origin) begin
			unique case (mode_q)
				lsum_pkg::MODE_WIDE_NBR: begin
					priority if (pos_s1.first_row) begin
						sum = a_l << 2;
					end else if (pos_s1.first_col) begin
						sum = (a_u + a_ur) << 1;
					end else if (!pos_s1.right) begin
						sum = a_l + a_ul + a_u + a_ur;
					end else begin
						sum = a_l + a_ul + (a_u << 1);
					end
				end
				lsum_pkg::MODE_NARROW_NBR: begin
					priority if (pos_s1.first_row) begin
						sum = a_first;
					end else if (pos_s1.first_col) begin
						sum = (a_u + a_ur) << 1;
					end else if (!pos_s1.right) begin
						sum = a_ul + (a_u << 1) + a_ur;
					end else begin
						sum = (a_ul + a_u) << 1;
					end
				end
				lsum_pkg::MODE_WIDE_COL: begin
					sum = pos_s1.first_row ? (a_l << 2) : (a_u << 2);
				end
				lsum_pkg::MODE_NARROW_COL: begin
					sum = pos_s1.first_row ? a_first : (a_u << 2);
				end
				default: sum = '0;
			endcase
		end
	end

	// stage 2: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s1_adv) begin
			s2_valid_q <= 1'b1;
		end else if (sum_out.ready) begin
			s2_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			sum_s2    <= sum[lsum_pkg::SUM_W-1:0];
			origin_s2 <= pos_s1.origin;
		end
	end

	assign sum_out.valid          = s2_valid_q;
	assign sum_out.local_sum      = sum_s2;
	assign sum_out.at_band_origin = origin_s2;

	`LSUM_ASSERT_NOW(a_origin_zero, sum_out.valid && sum_out.at_band_origin, sum_out.local_sum == '0, "band origin with nonzero sum")
	`LSUM_ASSERT_NOW(a_fr_single_write, fr_pend_q, !fr_we_take, "two first-row store writes in one cycle")
	`LSUM_ASSERT_NOW(a_prs_apart, take, prs_raddr != x, "line store read and write hit one entry")
	`LSUM_ASSERT_NEXT(a_s1_holds, s1_valid_q && !s1_adv, s1_valid_q && $stable(pos_s1), "stage 1 lost a stalled sample")
endmodule
`default_nettype wire

[hdl/lsum_ram.sv]
`default_nettype none
module lsum_ram #(
	parameter int DEPTH = lsum_pkg::MAX_LINE_DEF,
	parameter int WIDTH = lsum_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

[hdl/lsum_pos.sv]
`default_nettype none
`include "predictor_local_sum_core_assert.svh"
module lsum_pos #(
	parameter int MAX_LINE = lsum_pkg::MAX_LINE_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            take,
	input  wire logic                            start,
	input  wire logic [lsum_pkg::WIDTH_W-1:0]    line_width,
	input  wire logic [lsum_pkg::ROWS_W-1:0]     frame_rows,
	output logic      [$clog2(MAX_LINE)-1:0]     x,
	output lsum_pkg::pos_t                       pos
);
	localparam int COL_W = $clog2(MAX_LINE);
	localparam int CMP_W = ((COL_W + 1) > (lsum_pkg::WIDTH_W + 1)) ?
		(COL_W + 1) : (lsum_pkg::WIDTH_W + 1);
	localparam int ROW_W = lsum_pkg::ROWS_W;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             band_q;

	logic [CMP_W-1:0] w_ext;
	logic [CMP_W-1:0] w_eff;
	logic [ROW_W-1:0] y;
	logic [ROW_W:0]   y_inc;
	logic [ROW_W:0]   rows_eff;

	always_comb begin
		w_ext = CMP_W'(line_width);
		priority if (w_ext < CMP_W'(2)) begin
			w_eff = CMP_W'(2);
		end else if (w_ext > CMP_W'(MAX_LINE)) begin
			w_eff = CMP_W'(MAX_LINE);
		end else begin
			w_eff = w_ext;
		end
		rows_eff = (frame_rows == '0) ? (ROW_W+1)'(1) : {1'b0, frame_rows};
		x        = start ? '0 : col_q;
		y        = start ? '0 : row_q;
		y_inc    = {1'b0, y} + (ROW_W+1)'(1);
		pos.first_col = (x == '0);
		pos.first_row = (y == '0);
		pos.band_nz   = band_q & ~start;
		pos.right     = ((CMP_W'(x) + CMP_W'(1)) >= w_eff);
		pos.origin    = pos.first_col & pos.first_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			band_q <= 1'b0;
		end else if (take) begin
			if (pos.right) begin
				col_q <= '0;
				if (y_inc >= rows_eff) begin
					row_q  <= '0;
					band_q <= 1'b1;
				end else begin
					row_q  <= y_inc[ROW_W-1:0];
					band_q <= pos.band_nz;
				end
			end else begin
				col_q  <= x + COL_W'(1);
				row_q  <= y;
				band_q <= pos.band_nz;
			end
		end
	end

	`LSUM_ASSERT_NEXT(a_row_wrap, take && pos.right, col_q == '0, "column did not wrap at row end")
	`LSUM_ASSERT_NEXT(a_start_clears, take && start && !pos.right, row_q == '0 && !band_q, "start of image did not restart position")
endmodule
`default_nettype wire
